// ----- hdl/sqd_pkg.sv -----
// sqd_pkg: shared types and constants for the shortest queue dispatcher
// holds the transfer payload structs, controller states and the
// command/status bundles between sqd_ctrl and sqd_datapath
package sqd_pkg;

   localparam int CSR_WIDTH = 4;
   localparam logic [CSR_WIDTH-1:0] ACTIVE_RESET = 4'd8;

   typedef struct packed {
      logic       arrival;
      logic [6:0] service_time;
      logic       final_tick;
   } req_type;

   typedef struct packed {
      logic [2:0] chosen_queue;
      logic       accepted;
      logic       dropped;
      logic [7:0] done_mask;
      logic [7:0] total_waiting;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ARRIVE,
      ST_SERVE,
      ST_LOAD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic arrive;
      logic serve;
      logic load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic need_load;
      logic rsp_busy;
   } status_type;

endpackage

// ----- hdl/sqd_ctrl.sv -----
// sqd_ctrl: sequencer for one tick of the dispatcher
// walks scan, arrival, per-queue service and result hand-off; uses sqd_pkg
module sqd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sqd_pkg::status_type status,
   output sqd_pkg::cmd_type    cmd
);
   import sqd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.last) begin
               state_in = ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_SERVE;
         end
         ST_SERVE: begin
            cmd.serve = 1'b1;
            if (status.need_load) begin
               state_in = ST_LOAD;
            end else if (status.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = status.last ? ST_FINISH : ST_SERVE;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/sqd_datapath.sv -----
// sqd_datapath: queue state, service-time ring memory and result register
// executes the commands of sqd_ctrl one queue per cycle, apart from load steps; uses sqd_pkg
module sqd_datapath #(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sqd_pkg::req_type               req_data,
   output sqd_pkg::rsp_type               rsp_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sqd_pkg::CSR_WIDTH-1:0]  csr_data,
   input  sqd_pkg::cmd_type               cmd,
   output sqd_pkg::status_type            status
);
   import sqd_pkg::*;

   localparam int IW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int HW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int TW = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
   localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [HW:0]   DEPTH_S = (HW + 1)'(QUEUE_DEPTH);
   localparam logic [HW-1:0] HEAD_MAX = HW'(QUEUE_DEPTH - 1);

   // per-queue state, indexed through idx_ff (and through scan_best while scanning)
   logic [CW-1:0] count_ff [NUM_QUEUES];
   logic [CW-1:0] count_in [NUM_QUEUES];
   logic [HW-1:0] head_ff  [NUM_QUEUES];
   logic [HW-1:0] head_in  [NUM_QUEUES];
   logic [6:0]    front_ff [NUM_QUEUES];
   logic [6:0]    front_in [NUM_QUEUES];

   logic [6:0]    mem [MEM_DEPTH];
   logic [6:0]    rd_data_ff;

   req_type                item_ff, item_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [IW-1:0]          best_ff, best_in;
   logic [CW-1:0]          best_cnt_ff, best_cnt_in;
   logic [TW-1:0]          total_ff, total_in;
   logic                   acc_ff, acc_in;
   logic                   drop_ff, drop_in;
   logic [7:0]             done_ff, done_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CSR_WIDTH-1:0]   active_ff, active_in;

   logic [IW-1:0] n_last;
   logic [IW-1:0] idx_next;
   logic [IW-1:0] scan_best;
   logic [CW-1:0] cur_cnt;
   logic [HW-1:0] cur_head;
   logic [6:0]    cur_front;
   logic [HW-1:0] head_next;
   logic [HW:0]   slot_sum;
   logic [HW-1:0] slot;
   logic [AW-1:0] base_addr;
   logic          last;
   logic          finishing;
   logic          need_load;
   logic          mem_we;
   logic          mem_re;

   // clamp the active count to 1..NUM_QUEUES, kept as the last index
   always_comb begin
      if (active_ff == '0) begin
         n_last = '0;
      end else if (int'(active_ff) >= NUM_QUEUES) begin
         n_last = IW'(NUM_QUEUES - 1);
      end else begin
         n_last = IW'(active_ff - 4'd1);
      end
   end

   assign last      = (idx_ff == n_last);
   assign idx_next  = last ? '0 : IW'(idx_ff + 1'b1);
   assign cur_cnt   = count_ff[idx_ff];
   assign cur_head  = head_ff[idx_ff];
   assign cur_front = front_ff[idx_ff];
   assign head_next = (cur_head == HEAD_MAX) ? '0 : HW'(cur_head + 1'b1);
   assign finishing = (cur_cnt != '0) && (cur_front <= 7'd1);
   assign need_load = finishing && (cur_cnt > CW'(1));
   assign base_addr = AW'(idx_ff) * DEPTH_A;

   // tail slot of the ring, count is below depth whenever it is written
   assign slot_sum  = (HW + 1)'(cur_head) + (HW + 1)'(cur_cnt);
   assign slot      = (slot_sum >= DEPTH_S) ? HW'(slot_sum - DEPTH_S) : HW'(slot_sum);

   assign scan_best = ((idx_ff == '0) || (cur_cnt < best_cnt_ff)) ? idx_ff : best_ff;

   assign status.last      = last;
   assign status.need_load = need_load;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign mem_we = cmd.arrive && item_ff.arrival && (cur_cnt < DEPTH_C);
   assign mem_re = cmd.serve && need_load;

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      front_in     = front_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_cnt_in  = best_cnt_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      drop_in      = drop_ff;
      done_in      = done_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      active_in    = active_ff;

      if (csr_valid) begin
         active_in = csr_data;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.start) begin
         item_in = req_data;
         idx_in  = '0;
         acc_in  = 1'b0;
         drop_in = 1'b0;
         done_in = '0;
      end

      if (cmd.scan) begin
         best_in     = scan_best;
         best_cnt_in = count_ff[scan_best];
         idx_in      = last ? scan_best : IW'(idx_ff + 1'b1);
      end

      if (cmd.arrive) begin
         if (item_ff.arrival) begin
            if (cur_cnt >= DEPTH_C) begin
               drop_in = 1'b1;
            end else begin
               if (cur_cnt == '0) begin
                  front_in[idx_ff] = item_ff.service_time;
               end
               count_in[idx_ff] = CW'(cur_cnt + 1'b1);
               total_in         = TW'(total_ff + 1'b1);
               acc_in           = 1'b1;
            end
         end
         idx_in = '0;
      end

      if (cmd.serve) begin
         if (finishing) begin
            front_in[idx_ff] = '0;
            head_in[idx_ff]  = head_next;
            count_in[idx_ff] = CW'(cur_cnt - 1'b1);
            total_in         = TW'(total_ff - 1'b1);
            done_in          = done_ff | (8'd1 << idx_ff);
         end else if (cur_cnt != '0) begin
            front_in[idx_ff] = cur_front - 7'd1;
         end
         if (!need_load) begin
            idx_in = idx_next;
         end
      end

      if (cmd.load) begin
         front_in[idx_ff] = rd_data_ff;
         idx_in           = idx_next;
      end

      if (cmd.finish) begin
         rsp_in.chosen_queue  = 3'(best_ff);
         rsp_in.accepted      = acc_ff;
         rsp_in.dropped       = drop_ff;
         rsp_in.done_mask     = done_ff;
         rsp_in.total_waiting = 8'(total_ff);
         rsp_valid_in         = 1'b1;
         if (item_ff.final_tick) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
               count_in[q] = '0;
               head_in[q]  = '0;
               front_in[q] = '0;
            end
            total_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            count_ff[q] <= '0;
            head_ff[q]  <= '0;
            front_ff[q] <= '0;
         end
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_RESET;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         front_ff     <= front_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_cnt_ff <= best_cnt_in;
      acc_ff      <= acc_in;
      drop_ff     <= drop_in;
      done_ff     <= done_in;
      rsp_ff      <= rsp_in;
   end

   // service-time rings, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[base_addr + AW'(slot)] <= item_ff.service_time;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[base_addr + AW'(head_next)];
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

// ----- hdl/shortest_queue_dispatcher.sv -----
// shortest_queue_dispatcher: top level, join-shortest-queue dispatch of clients
// joins sqd_ctrl and sqd_datapath; uses sqd_pkg
//
// Usage:
//   req_* : one transfer per time tick (arrival, service_time, final_tick).
//   rsp_* : one result transfer per tick (chosen_queue, accepted, dropped,
//           done_mask, total_waiting), in tick order.
//   csr_* : writes active_windows (queues in use from queue 0); csr_ready is
//           always high, write only while no tick is in flight.
// Timing: after the accepting edge the scan pass visits the n active queues,
//   the arrival is placed, and the service pass visits them again, adding
//   a load step for every queue whose front client finishes while others
//   still wait behind it (the next service time is read from the shared
//   ring memory through its single registered read port). Both passes visit
//   one queue per cycle, apart from those load steps. A new tick is accepted
//   in the cycle after the previous result is loaded into the output register.
// Reset: synchronous; all queues empty, active_windows = 8, no result valid.
//   The ring memory is not cleared; only written entries are ever read.
// Stall: a held result keeps the next tick parked at its last step until
//   rsp_ready frees the output register.
module shortest_queue_dispatcher #(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sqd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sqd_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sqd_pkg::CSR_WIDTH-1:0] csr_data
);
   import sqd_pkg::*;

   cmd_type    cmd;
   status_type status;

   sqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sqd_datapath #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
